[rtl/bbc_pkg.sv]
package bbc_pkg;

  localparam int STACK_DEPTH   = 1024;
  localparam int POSITION_BITS = 16;
  localparam int ADDR_W        = $clog2(STACK_DEPTH);
  localparam int COUNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int OUT_POS_W     = 16;

  localparam logic [7:0] CH_ROUND_OPEN   = 8'h28;  // (
  localparam logic [7:0] CH_ROUND_CLOSE  = 8'h29;  // )
  localparam logic [7:0] CH_SQUARE_OPEN  = 8'h5B;  // [
  localparam logic [7:0] CH_SQUARE_CLOSE = 8'h5D;  // ]
  localparam logic [7:0] CH_CURLY_OPEN   = 8'h7B;  // {
  localparam logic [7:0] CH_CURLY_CLOSE  = 8'h7D;  // }

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [COUNT_W-1:0]       count_t;
  typedef logic [ADDR_W-1:0]        addr_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_ROUND  = 2'd1,
    KIND_SQUARE = 2'd2,
    KIND_CURLY  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MISMATCH  = 2'd1,
    ST_UNMATCHED = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef struct packed {
    kind_t kind;
    pos_t  pos;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic                 valid;
    status_t              status;
    logic [OUT_POS_W-1:0] position;
  } result_t;

  function automatic kind_t opener_kind(input logic [7:0] c);
    kind_t k;
    k = KIND_NONE;
    unique case (c)
      CH_ROUND_OPEN:  k = KIND_ROUND;
      CH_SQUARE_OPEN: k = KIND_SQUARE;
      CH_CURLY_OPEN:  k = KIND_CURLY;
      default:        k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic kind_t closer_kind(input logic [7:0] c);
    kind_t k;
    k = KIND_NONE;
    unique case (c)
      CH_ROUND_CLOSE:  k = KIND_ROUND;
      CH_SQUARE_CLOSE: k = KIND_SQUARE;
      CH_CURLY_CLOSE:  k = KIND_CURLY;
      default:         k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

[rtl/bbc_char_if.sv]
interface bbc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_string;

  modport source (output valid, output char_byte, output end_of_string, input ready);
  modport sink (input valid, input char_byte, input end_of_string, output ready);
endinterface

[rtl/bbc_result_if.sv]
interface bbc_result_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [bbc_pkg::OUT_POS_W-1:0] position;

  modport source (output valid, output status, output position, input ready);
  modport sink (input valid, input status, input position, output ready);
endinterface

[rtl/bracket_balance_checker_top.sv]
// Checks strings for balanced (), [] and {} brackets, one byte per beat with
// end_of_string on the last byte. Each string gives one result: success with
// position 0, a mismatched closer (also a closer on an empty stack) at its
// 1-based position, stack overflow at the opener that found the stack full,
// or the position of the innermost opener left unmatched at the end. After an
// error the rest of the string gives no result. Throughput is one byte per
// clock unless input is held off; the top of the stack lives in a register
// and the entries below it in a single-port-read ram with a registered read,
// so the entry under the top is always prefetched and a pop never stalls. The
// result appears in the cycle after the last byte and waits in an output
// register; input is held off only while that register is full and not being
// taken. No clearing pass after reset.
module bracket_balance_checker_top (
  input  logic         clk,
  input  logic         rst,
  bbc_char_if.sink     chars,
  bbc_result_if.source results
);

  logic             accept;
  bbc_pkg::result_t res;
  logic             out_valid;
  logic [1:0]       out_status;
  logic [bbc_pkg::OUT_POS_W-1:0] out_position;

  assign chars.ready = !out_valid || results.ready;
  assign accept      = chars.valid && chars.ready;

  bbc_core u_core (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .char_byte     (chars.char_byte),
    .end_of_string (chars.end_of_string),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res.valid;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res.valid) begin
      out_status   <= res.status;
      out_position <= res.position;
    end
  end

  assign results.valid    = out_valid;
  assign results.status   = out_status;
  assign results.position = out_position;

endmodule

[rtl/bbc_stack_ram.sv]
module bbc_stack_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 18
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/bbc_core.sv]
module bbc_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       char_byte,
  input  logic             end_of_string,
  output bbc_pkg::result_t res
);

  bbc_pkg::count_t count, count_next;
  bbc_pkg::pos_t   position, position_next;
  logic            err, err_next;
  bbc_pkg::entry_t top, top_next;
  logic            byp;
  bbc_pkg::entry_t byp_data;

  bbc_pkg::entry_t below;
  bbc_pkg::entry_t rd_entry;
  logic [bbc_pkg::ENTRY_W-1:0] rdata;
  bbc_pkg::kind_t  ok_kind, ck_kind;
  bbc_pkg::pos_t   pos_inc;
  bbc_pkg::count_t wr_cnt, rd_cnt;
  logic            push, pop, err_now;

  assign rd_entry = bbc_pkg::entry_t'(rdata);
  // entry below the top: just written last cycle, or from the ram
  assign below    = byp ? byp_data : rd_entry;
  assign ok_kind  = bbc_pkg::opener_kind(char_byte);
  assign ck_kind  = bbc_pkg::closer_kind(char_byte);
  assign pos_inc  = (position != '1) ? position + bbc_pkg::pos_t'(1) : position;

  always_comb begin
    count_next    = count;
    position_next = position;
    err_next      = err;
    top_next      = top;
    push          = 1'b0;
    pop           = 1'b0;
    err_now       = 1'b0;
    res           = '0;
    res.status    = bbc_pkg::ST_OK;
    if (accept) begin
      if (err) begin
        if (end_of_string) begin
          count_next    = '0;
          position_next = '0;
          err_next      = 1'b0;
        end
      end else begin
        position_next = pos_inc;
        if (ok_kind != bbc_pkg::KIND_NONE) begin
          if (count == bbc_pkg::count_t'(bbc_pkg::STACK_DEPTH)) begin
            err_now      = 1'b1;
            res.valid    = 1'b1;
            res.status   = bbc_pkg::ST_OVERFLOW;
            res.position = pos_inc[bbc_pkg::OUT_POS_W-1:0];
          end else begin
            push          = 1'b1;
            count_next    = count + bbc_pkg::count_t'(1);
            top_next.kind = ok_kind;
            top_next.pos  = pos_inc;
          end
        end else if (ck_kind != bbc_pkg::KIND_NONE) begin
          if (count == '0 || top.kind != ck_kind) begin
            err_now      = 1'b1;
            res.valid    = 1'b1;
            res.status   = bbc_pkg::ST_MISMATCH;
            res.position = pos_inc[bbc_pkg::OUT_POS_W-1:0];
          end else begin
            pop        = 1'b1;
            count_next = count - bbc_pkg::count_t'(1);
            top_next   = below;
          end
        end
        err_next = err_now;
        if (end_of_string) begin
          if (!err_now) begin
            res.valid = 1'b1;
            if (count_next == '0) begin
              res.status   = bbc_pkg::ST_OK;
              res.position = '0;
            end else begin
              res.status   = bbc_pkg::ST_UNMATCHED;
              res.position = top_next.pos[bbc_pkg::OUT_POS_W-1:0];
            end
          end
          count_next    = '0;
          position_next = '0;
          err_next      = 1'b0;
        end
      end
    end
  end

  // old top spills into the ram at count-1; read always tracks count_next-2
  assign wr_cnt = count - bbc_pkg::count_t'(1);
  assign rd_cnt = count_next - bbc_pkg::count_t'(2);

  bbc_stack_ram #(
    .DEPTH (bbc_pkg::STACK_DEPTH),
    .WIDTH (bbc_pkg::ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (push && count != '0),
    .waddr (wr_cnt[bbc_pkg::ADDR_W-1:0]),
    .wdata (top),
    .raddr (rd_cnt[bbc_pkg::ADDR_W-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      position <= '0;
      err      <= 1'b0;
      byp      <= 1'b0;
    end else begin
      count    <= count_next;
      position <= position_next;
      err      <= err_next;
      byp      <= push && count != '0;
    end
  end

  always_ff @(posedge clk) begin
    top      <= top_next;
    byp_data <= top;
  end

endmodule
